/* rtl/wbm_pkg.sv */
// Shared constants, codes and types for the weighted block multilook core.
`timescale 1ns / 1ps
package wbm_pkg;

   localparam int SAMPLE_W           = 16;
   localparam int WEIGHT_W           = 8;
   localparam int LINE_REG_W         = 13;
   localparam int LOOKS_REG_W        = 5;
   localparam int MODE_W             = 2;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 16;
   localparam int DEF_MAX_LINE_WIDTH = 4096;
   localparam int DEF_MAX_LOOKS      = 16;

   localparam logic [LINE_REG_W-1:0]  RST_LINE_WIDTH  = LINE_REG_W'(4096);
   localparam logic [LOOKS_REG_W-1:0] RST_LOOKS       = LOOKS_REG_W'(1);
   localparam logic [LINE_REG_W-1:0]  RST_COLS_LOOKED = LINE_REG_W'(4096);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINE_WIDTH   = 3'd0,
      CSR_COLS_LOOKS   = 3'd1,
      CSR_ROWS_LOOKS   = 3'd2,
      CSR_COLS_LOOKED  = 3'd3,
      CSR_WEIGHT_MODE  = 3'd4,
      CSR_NODATA_VALUE = 3'd5
   } csr_index_type;

   localparam logic [MODE_W-1:0] MODE_PLAIN    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WEIGHTED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_NODATA   = 2'd2;

endpackage

/* rtl/wbm_channels_if.sv */
// Pixel request and block-mean response channel interfaces.
`timescale 1ns / 1ps
interface wbm_req_if import wbm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [WEIGHT_W-1:0]        weight;
   logic                       first_of_frame;

   modport source (output valid, output sample, output weight, output first_of_frame,
                   input ready);
   modport sink (input valid, input sample, input weight, input first_of_frame,
                 output ready);
endinterface

interface wbm_rsp_if import wbm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] mean;
   logic                       valid_res;
   logic                       last_in_line;

   modport source (output valid, output mean, output valid_res, output last_in_line,
                   input ready);
   modport sink (input valid, input mean, input valid_res, input last_in_line,
                 output ready);
endinterface

/* rtl/wbm_line_store.sv */
// Column line store: one write port, one registered read port.
`timescale 1ns / 1ps
module wbm_line_store #(
   parameter int DEPTH   = 4096,
   parameter int ADDR_W  = 12,
   parameter int ENTRY_W = 49
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [ENTRY_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [ENTRY_W-1:0] wr_data
);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/wbm_divider.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wbm_divider #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 16,
   parameter int QUO_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int SH_W  = DEN_W + QUO_W - 1;
   localparam int CMP_W = ((NUM_W > SH_W) ? NUM_W : SH_W) + 1;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [SH_W-1:0]  den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CMP_W-1:0] rem_x, den_x;
   logic             fits;

   always_comb begin
      rem_x   = CMP_W'(rem_ff);
      den_x   = CMP_W'(den_ff);
      fits    = rem_x >= den_x;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numerator;
         den_in  = SH_W'(denominator) << (QUO_W - 1);
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = NUM_W'(rem_x - den_x);
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         den_in = den_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/weighted_block_multilook_core.sv */
// Top level: weighted block multilook with line store and iterative divider.
//
// Pixels arrive in raster order on req_bus (valid/ready); each transfer carries a
// sample, a weight and first_of_frame, which restarts all counters. Block means
// leave on rsp_bus, one per complete cols_looks x rows_looks block.
// Registers are written through csr_we/csr_index/csr_wdata; the user must do so
// only while the core is idle, which the core does not enforce. A pixel that
// closes no horizontal group is taken in S_IDLE. A pixel that closes a horizontal
// group then passes S_READ (line store read) and S_UPDATE (read-modify-write).
// A pixel that closes a full block then waits in S_DIVIDE for the 16 quotient
// bits and the done flag, then S_OUTPUT loads the output register. No new pixel
// is taken outside S_IDLE. The output register holds a finished result while the
// next pixel is taken; if rsp_bus stalls, a second finished result waits in the
// divider until the output register frees, and req_bus.ready stays low meanwhile.
// Synchronous reset clears counters, registers to defaults and drops rsp valid.
// The line store needs no clearing: the first row of a block overwrites entries.
`timescale 1ns / 1ps
module weighted_block_multilook_core import wbm_pkg::*; #(
   parameter int MAX_LINE_WIDTH = DEF_MAX_LINE_WIDTH,
   parameter int MAX_LOOKS      = DEF_MAX_LOOKS
) (
   input  logic                   clock,
   input  logic                   reset,
   wbm_req_if.sink                req_bus,
   wbm_rsp_if.source              rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W     = $clog2(MAX_LINE_WIDTH + 1);
   localparam int ADDR_W    = $clog2(MAX_LINE_WIDTH);
   localparam int LOOK_W    = $clog2(MAX_LOOKS + 1);
   localparam int LOG_LOOKS = $clog2(MAX_LOOKS);
   localparam int PROD_W    = SAMPLE_W + WEIGHT_W + 1;
   localparam int HS_W      = PROD_W + LOG_LOOKS;
   localparam int HW_W      = WEIGHT_W + LOG_LOOKS;
   localparam int CS_W      = HS_W + LOG_LOOKS;
   localparam int CW_W      = HW_W + LOG_LOOKS;
   localparam int ENTRY_W   = CS_W + CW_W;
   localparam int PW        = CNT_W + 1 + LOOK_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_UPDATE, S_DIVIDE, S_OUTPUT
   } state_type;

   // configuration
   logic [LINE_REG_W-1:0]      line_width_ff, cols_looked_ff;
   logic [LOOKS_REG_W-1:0]     cols_looks_ff, rows_looks_ff;
   logic [MODE_W-1:0]          weight_mode_ff;
   logic signed [SAMPLE_W-1:0] nodata_ff;

   logic [CNT_W-1:0]  lw_eff, ncol_eff;
   logic [LOOK_W-1:0] cl_eff, rl_eff;

   // counters and horizontal sums
   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [LOOK_W-1:0]        col_look_ff, col_look_in, row_look_ff, row_look_in;
   logic signed [HS_W-1:0]   hs_ff, hs_in;
   logic [HW_W-1:0]          hw_ff, hw_in;

   // pending block job
   logic [ADDR_W-1:0]        job_oc_ff, job_oc_in;
   logic                     job_first_ff, job_first_in;
   logic                     job_emit_ff, job_emit_in;
   logic                     job_last_ff, job_last_in;
   logic signed [HS_W-1:0]   job_hs_ff, job_hs_in;
   logic [HW_W-1:0]          job_hw_ff, job_hw_in;
   logic                     res_neg_ff, res_neg_in;
   logic                     res_ok_ff, res_ok_in;
   logic                     res_last_ff, res_last_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic                       rsp_last_ff, rsp_last_in;

   // datapath wires
   logic                       accept;
   logic [CNT_W-1:0]           b_in, b_oc;
   logic [LOOK_W-1:0]          b_look, b_row, look1, row1;
   logic signed [HS_W-1:0]     b_hs, hs_sum;
   logic [HW_W-1:0]            b_hw, hw_sum;
   logic [CNT_W:0]             oc1;
   logic [PW-1:0]              span, span2;
   logic                       active, grp_done;
   logic [WEIGHT_W-1:0]        w;
   logic signed [WEIGHT_W:0]   ws;
   logic signed [PROD_W-1:0]   prod;
   logic [CNT_W-1:0]           in1;

   logic                       rd_en, wr_en, div_start, div_done;
   logic [ENTRY_W-1:0]         rd_data, wr_data;
   logic signed [CS_W-1:0]     old_sum, new_sum;
   logic [CW_W-1:0]            old_wt, new_wt;
   logic [CS_W-1:0]            num_mag;
   logic [SAMPLE_W-1:0]        quotient, mag_q;

   // effective register values
   always_comb begin
      if (line_width_ff == '0) lw_eff = CNT_W'(1);
      else if (32'(line_width_ff) > MAX_LINE_WIDTH) lw_eff = CNT_W'(MAX_LINE_WIDTH);
      else lw_eff = CNT_W'(line_width_ff);
      if (cols_looked_ff == '0) ncol_eff = CNT_W'(1);
      else if (32'(cols_looked_ff) > MAX_LINE_WIDTH) ncol_eff = CNT_W'(MAX_LINE_WIDTH);
      else ncol_eff = CNT_W'(cols_looked_ff);
      if (cols_looks_ff == '0) cl_eff = LOOK_W'(1);
      else if (32'(cols_looks_ff) > MAX_LOOKS) cl_eff = LOOK_W'(MAX_LOOKS);
      else cl_eff = LOOK_W'(cols_looks_ff);
      if (rows_looks_ff == '0) rl_eff = LOOK_W'(1);
      else if (32'(rows_looks_ff) > MAX_LOOKS) rl_eff = LOOK_W'(MAX_LOOKS);
      else rl_eff = LOOK_W'(rows_looks_ff);
   end

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   // pixel step
   always_comb begin
      if (req_bus.first_of_frame) begin
         b_in = '0; b_oc = '0; b_look = '0; b_row = '0; b_hs = '0; b_hw = '0;
      end else begin
         b_in = in_col_ff; b_oc = out_col_ff; b_look = col_look_ff;
         b_row = row_look_ff; b_hs = hs_ff; b_hw = hw_ff;
      end
      case (weight_mode_ff)
         MODE_WEIGHTED: w = req_bus.weight;
         MODE_NODATA:   w = (req_bus.sample == nodata_ff) ? '0 : WEIGHT_W'(1);
         default:       w = WEIGHT_W'(1);
      endcase
      ws     = {1'b0, w};
      prod   = ws * req_bus.sample;
      hs_sum = b_hs + HS_W'(prod);
      hw_sum = b_hw + HW_W'(w);
      oc1    = {1'b0, b_oc} + (CNT_W + 1)'(1);
      span   = PW'(oc1) * PW'(cl_eff);
      span2  = span + PW'(cl_eff);
      active = (b_oc < ncol_eff) && (span <= PW'(lw_eff));
      look1  = b_look + LOOK_W'(1);
      row1   = b_row + LOOK_W'(1);
      grp_done = active && (look1 >= cl_eff);
      in1    = b_in + CNT_W'(1);
   end

   // line store update values
   always_comb begin
      old_sum = signed'(rd_data[ENTRY_W-1:CW_W]);
      old_wt  = rd_data[CW_W-1:0];
      new_sum = job_first_ff ? CS_W'(job_hs_ff) : old_sum + CS_W'(job_hs_ff);
      new_wt  = job_first_ff ? CW_W'(job_hw_ff) : old_wt + CW_W'(job_hw_ff);
      num_mag = new_sum[CS_W-1] ? CS_W'(-new_sum) : CS_W'(new_sum);
      wr_data = {new_sum, new_wt};
      mag_q   = res_neg_ff ? -quotient : quotient;
   end

   assign rd_en     = (state_ff == S_READ);
   assign wr_en     = (state_ff == S_UPDATE);
   assign div_start = (state_ff == S_UPDATE) && job_emit_ff;

   // next state and register values
   always_comb begin
      state_in     = state_ff;
      in_col_in    = in_col_ff;
      out_col_in   = out_col_ff;
      col_look_in  = col_look_ff;
      row_look_in  = row_look_ff;
      hs_in        = hs_ff;
      hw_in        = hw_ff;
      job_oc_in    = job_oc_ff;
      job_first_in = job_first_ff;
      job_emit_in  = job_emit_ff;
      job_last_in  = job_last_ff;
      job_hs_in    = job_hs_ff;
      job_hw_in    = job_hw_ff;
      res_neg_in   = res_neg_ff;
      res_ok_in    = res_ok_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               in_col_in   = b_in;
               out_col_in  = b_oc;
               col_look_in = b_look;
               row_look_in = b_row;
               hs_in       = b_hs;
               hw_in       = b_hw;
               if (active) begin
                  hs_in       = hs_sum;
                  hw_in       = hw_sum;
                  col_look_in = look1;
               end
               if (grp_done) begin
                  job_oc_in    = b_oc[ADDR_W-1:0];
                  job_first_in = (b_row == '0);
                  job_emit_in  = (row1 >= rl_eff);
                  job_last_in  = (oc1 == {1'b0, ncol_eff}) || (span2 > PW'(lw_eff));
                  job_hs_in    = hs_sum;
                  job_hw_in    = hw_sum;
                  hs_in        = '0;
                  hw_in        = '0;
                  col_look_in  = '0;
                  out_col_in   = oc1[CNT_W-1:0];
                  state_in     = S_READ;
               end
               if (in1 >= lw_eff) begin
                  in_col_in   = '0;
                  col_look_in = '0;
                  out_col_in  = '0;
                  hs_in       = '0;
                  hw_in       = '0;
                  row_look_in = (row1 >= rl_eff) ? '0 : row1;
               end else begin
                  in_col_in = in1;
               end
            end
         end
         S_READ: state_in = S_UPDATE;
         S_UPDATE: begin
            res_neg_in  = new_sum[CS_W-1];
            res_ok_in   = (new_wt != '0);
            res_last_in = job_last_ff;
            state_in    = job_emit_ff ? S_DIVIDE : S_IDLE;
         end
         S_DIVIDE: if (div_done) state_in = S_OUTPUT;
         S_OUTPUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = res_ok_ff ? signed'(mag_q) : '0;
               rsp_ok_in    = res_ok_ff;
               rsp_last_in  = res_last_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      job_oc_ff    <= job_oc_in;
      job_first_ff <= job_first_in;
      job_emit_ff  <= job_emit_in;
      job_last_ff  <= job_last_in;
      job_hs_ff    <= job_hs_in;
      job_hw_ff    <= job_hw_in;
      res_neg_ff   <= res_neg_in;
      res_ok_ff    <= res_ok_in;
      res_last_ff  <= res_last_in;
      rsp_mean_ff  <= rsp_mean_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         in_col_ff      <= '0;
         out_col_ff     <= '0;
         col_look_ff    <= '0;
         row_look_ff    <= '0;
         hs_ff          <= '0;
         hw_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
         line_width_ff  <= RST_LINE_WIDTH;
         cols_looks_ff  <= RST_LOOKS;
         rows_looks_ff  <= RST_LOOKS;
         cols_looked_ff <= RST_COLS_LOOKED;
         weight_mode_ff <= MODE_PLAIN;
         nodata_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         in_col_ff    <= in_col_in;
         out_col_ff   <= out_col_in;
         col_look_ff  <= col_look_in;
         row_look_ff  <= row_look_in;
         hs_ff        <= hs_in;
         hw_ff        <= hw_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_LINE_WIDTH:   line_width_ff  <= csr_wdata[LINE_REG_W-1:0];
               CSR_COLS_LOOKS:   cols_looks_ff  <= csr_wdata[LOOKS_REG_W-1:0];
               CSR_ROWS_LOOKS:   rows_looks_ff  <= csr_wdata[LOOKS_REG_W-1:0];
               CSR_COLS_LOOKED:  cols_looked_ff <= csr_wdata[LINE_REG_W-1:0];
               CSR_WEIGHT_MODE:  weight_mode_ff <= csr_wdata[MODE_W-1:0];
               CSR_NODATA_VALUE: nodata_ff      <= signed'(csr_wdata[SAMPLE_W-1:0]);
               default: ;
            endcase
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.mean         = rsp_mean_ff;
   assign rsp_bus.valid_res    = rsp_ok_ff;
   assign rsp_bus.last_in_line = rsp_last_ff;

   wbm_line_store #(
      .DEPTH   (MAX_LINE_WIDTH),
      .ADDR_W  (ADDR_W),
      .ENTRY_W (ENTRY_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (job_oc_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (job_oc_ff),
      .wr_data (wr_data)
   );

   wbm_divider #(
      .NUM_W (CS_W),
      .DEN_W (CW_W),
      .QUO_W (SAMPLE_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (num_mag),
      .denominator (new_wt),
      .done        (div_done),
      .quotient    (quotient)
   );

endmodule

/* rtl/wbm_checker.sv */
// Port-level checks for the multilook core, bound to the top level.
`timescale 1ns / 1ps
module wbm_checker import wbm_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_mean,
   input logic                       rsp_valid_res
);

   // no-weight block reports a zero mean
   a_zero_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_mean == '0)
      else $error("mean not zero on empty block");

   // a result never shows up in the cycle after a pixel transfer
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early after request transfer");

   // reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind weighted_block_multilook_core wbm_checker u_wbm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_mean      (rsp_bus.mean),
   .rsp_valid_res (rsp_bus.valid_res)
);

/* test/weighted_block_multilook_core_tb.sv */
// Self-checking testbench for the weighted block multilook core.
`timescale 1ns / 1ps
module weighted_block_multilook_core_tb;
   import wbm_pkg::*;

   localparam int LINE_CAP   = 4096;
   localparam int LOOKS_CAP  = 16;
   localparam int ITEM_GOAL  = 650;
   localparam int QUIET_FROM = 560;
   localparam int SETTLE     = 40;
   localparam int CYCLE_CAP  = 600000;
   localparam int WIDE_LEN   = 96;

   typedef enum {ROW_PIXEL, ROW_REGS} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic signed [15:0]    sample;
      logic [7:0]            weight;
      bit                    fof;
      bit                    typed;
      logic signed [15:0]    mean;
      bit                    vres;
      bit                    last;
   } stim_row_type;

   typedef struct {
      logic signed [15:0] mean;
      bit                 vres;
      bit                 last;
   } block_mean_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   wbm_req_if req_bus ();
   wbm_rsp_if rsp_bus ();

   weighted_block_multilook_core DUT (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [12:0] reg_line_width  = 13'd4096;
   logic [4:0]  reg_cols_looks  = 5'd1;
   logic [4:0]  reg_rows_looks  = 5'd1;
   logic [12:0] reg_cols_looked = 13'd4096;
   logic [1:0]  reg_mode        = MODE_PLAIN;
   logic [15:0] reg_nodata      = 16'd0;

   longint      hsum;
   int unsigned hweight, in_col, col_look, out_col, row_look;
   longint      col_sum [LINE_CAP];
   int unsigned col_weight [LINE_CAP];

   block_mean_type pending_means[$];
   int          error_count = 0;
   int          sent_count  = 0;
   bit          quiet       = 1'b0;
   int          cycle_count = 0;
   int          stall_left  = 0;

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic bit model_pixel(input logic signed [15:0] s, input logic [7:0] wt,
                                      input bit fof, output block_mean_type res);
      int unsigned lw, cl, rl, nc, w, oc, wsum;
      longint      q;
      bit          hit;
      lw  = clampu(reg_line_width, 1, LINE_CAP);
      cl  = clampu(reg_cols_looks, 1, LOOKS_CAP);
      rl  = clampu(reg_rows_looks, 1, LOOKS_CAP);
      nc  = clampu(reg_cols_looked, 1, LINE_CAP);
      hit = 1'b0;
      res = '{mean: '0, vres: 1'b0, last: 1'b0};
      if (lw / cl < nc) nc = lw / cl;
      if (reg_mode == MODE_WEIGHTED) w = wt;
      else if (reg_mode == MODE_NODATA) w = (s == $signed(reg_nodata)) ? 0 : 1;
      else w = 1;
      if (fof) begin
         in_col = 0; col_look = 0; out_col = 0; row_look = 0; hsum = 0; hweight = 0;
      end
      if (out_col < nc) begin
         hsum += longint'(w) * longint'(s);
         hweight += w;
         col_look++;
         if (col_look >= cl) begin
            oc = out_col;
            if (row_look == 0) begin
               col_sum[oc] = hsum;
               col_weight[oc] = hweight;
            end else begin
               col_sum[oc] += hsum;
               col_weight[oc] += hweight;
            end
            if (row_look + 1 >= rl) begin
               wsum = col_weight[oc];
               q = (wsum != 0) ? col_sum[oc] / longint'(wsum) : 0;
               res.mean = q[15:0];
               res.vres = (wsum != 0);
               res.last = (oc + 1 == nc);
               hit = 1'b1;
            end
            hsum = 0; hweight = 0; col_look = 0; out_col++;
         end
      end
      in_col++;
      if (in_col >= lw) begin
         in_col = 0; col_look = 0; out_col = 0; hsum = 0; hweight = 0;
         row_look++;
         if (row_look >= rl) row_look = 0;
      end
      return hit;
   endfunction

   task automatic send_pixel(input stim_row_type row);
      block_mean_type res;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.sample         <= row.sample;
      req_bus.weight         <= row.weight;
      req_bus.first_of_frame <= row.fof;
      do @(posedge clock); while (!req_bus.ready);
      if (model_pixel(row.sample, row.weight, row.fof, res)) begin
         if (row.typed) res = '{mean: row.mean, vres: row.vres, last: row.last};
         pending_means.push_back(res);
      end
      sent_count++;
      if (sent_count >= QUIET_FROM) quiet = 1'b1;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_regs(input logic [12:0] lw, input logic [4:0] cl, input logic [4:0] rl,
                             input logic [12:0] nc, input logic [1:0] md,
                             input logic [15:0] nd);
      logic [15:0] vals [6];
      vals = '{16'(lw), 16'(cl), 16'(rl), 16'(nc), 16'(md), nd};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      reg_line_width  = lw;
      reg_cols_looks  = cl;
      reg_rows_looks  = rl;
      reg_cols_looked = nc;
      reg_mode        = md;
      reg_nodata      = nd;
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin
      block_mean_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_means.size() == 0) begin
               $display("%0t: unexpected transfer mean=%0d valid_res=%0b last=%0b", $time,
                        rsp_bus.mean, rsp_bus.valid_res, rsp_bus.last_in_line);
               error_count++;
            end else begin
               want = pending_means.pop_front();
               if (rsp_bus.mean !== want.mean || rsp_bus.valid_res !== want.vres ||
                   rsp_bus.last_in_line !== want.last) begin
                  $display("%0t: expected mean=%0d valid_res=%0b last=%0b, got %0d %0b %0b",
                           $time, want.mean, want.vres, want.last, rsp_bus.mean,
                           rsp_bus.valid_res, rsp_bus.last_in_line);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("weighted_block_multilook_core test failed");
         $finish;
      end
   end

   function automatic stim_row_type px(logic signed [15:0] s, logic [7:0] w, bit f);
      return '{kind: ROW_PIXEL, sample: s, weight: w, fof: f, typed: 1'b0,
               mean: '0, vres: 1'b0, last: 1'b0};
   endfunction

   function automatic stim_row_type pxe(logic signed [15:0] s, logic [7:0] w, bit f,
                                        logic signed [15:0] m, bit v, bit l);
      return '{kind: ROW_PIXEL, sample: s, weight: w, fof: f, typed: 1'b1,
               mean: m, vres: v, last: l};
   endfunction

   initial begin
      stim_row_type directed [$];
      stim_row_type row;
      int unsigned lw, cl, rl, nc, frame_len, fit;
      bit          wide_done, wide_now;
      logic [1:0]  md;
      logic [15:0] nd;
      logic signed [15:0] s;

      req_bus.valid          = 1'b0;
      req_bus.sample         = '0;
      req_bus.weight         = '0;
      req_bus.first_of_frame = 1'b0;
      wide_done = 1'b0;
      wide_now  = 1'b0;
      hsum = 0; hweight = 0; in_col = 0; col_look = 0; out_col = 0; row_look = 0;
      foreach (col_sum[i]) begin
         col_sum[i] = 0;
         col_weight[i] = 0;
      end

      // reset defaults: every pixel is its own block
      directed.push_back(pxe(16'sh7FFF, 8'h00, 1'b1, 16'sh7FFF, 1'b1, 1'b0));
      directed.push_back(pxe(16'sh8000, 8'hFF, 1'b0, 16'sh8000, 1'b1, 1'b0));
      directed.push_back(pxe(16'sh0000, 8'h55, 1'b0, 16'sh0000, 1'b1, 1'b0));
      directed.push_back('{kind: ROW_REGS, sample: 16'sd0, default: '0});
      // 2x2 blocks, plain mode, sample extremes
      directed.push_back(px(16'sh7FFF, 8'h00, 1'b1));
      directed.push_back(px(16'sh7FFF, 8'h00, 1'b0));
      directed.push_back(px(16'sh8000, 8'h00, 1'b0));
      directed.push_back(px(16'sh8000, 8'h00, 1'b0));
      directed.push_back(px(16'sh7FFF, 8'h00, 1'b0));
      directed.push_back(pxe(16'sh7FFF, 8'h00, 1'b0, 16'sh7FFF, 1'b1, 1'b0));
      directed.push_back(px(16'sh8000, 8'h00, 1'b0));
      directed.push_back(pxe(16'sh8000, 8'h00, 1'b0, 16'sh8000, 1'b1, 1'b1));
      directed.push_back('{kind: ROW_REGS, sample: 16'sd1, default: '0});
      // weighted mode: zero weight sum, then full and unit weights
      directed.push_back(px(16'sd100, 8'h00, 1'b1));
      directed.push_back(px(16'sd5, 8'h00, 1'b0));
      directed.push_back(px(16'sh7FFF, 8'hFF, 1'b0));
      directed.push_back(px(-16'sd7, 8'hFF, 1'b0));
      directed.push_back(px(16'sd3, 8'h00, 1'b0));
      directed.push_back(pxe(16'sd9, 8'h00, 1'b0, 16'sd0, 1'b0, 1'b0));
      directed.push_back(px(16'sh8000, 8'hFF, 1'b0));
      directed.push_back(px(16'sd7, 8'h01, 1'b0));
      directed.push_back('{kind: ROW_REGS, sample: 16'sd2, default: '0});
      // no-data mode, 3x1 blocks with a masked sample
      directed.push_back(px(-16'sd5, 8'h00, 1'b1));
      directed.push_back(px(16'sd10, 8'h00, 1'b0));
      directed.push_back(px(-16'sd3, 8'h00, 1'b0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         row = directed[i];
         if (row.kind == ROW_REGS) begin
            drain();
            case (row.sample)
               0: write_regs(13'd4, 5'd2, 5'd2, 13'd2, MODE_PLAIN, 16'd0);
               1: write_regs(13'd4, 5'd2, 5'd2, 13'd2, MODE_WEIGHTED, 16'd0);
               default: write_regs(13'd3, 5'd3, 5'd1, 13'd1, MODE_NODATA, 16'hFFFB);
            endcase
         end else begin
            send_pixel(row);
         end
      end

      while (sent_count < ITEM_GOAL) begin
         drain();
         wide_now = 1'b0;
         if (!wide_done && (sent_count > 300 || $urandom_range(0, 15) == 0)) begin
            wide_done = 1'b1;
            wide_now  = 1'b1;
            lw = 8191; cl = 16; rl = 1; nc = 8191;
         end else begin
            lw = $urandom_range(1, 24);
            cl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            rl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3);
            if (lw == 24 && $urandom_range(0, 1)) lw = 0;
            fit = clampu(lw, 1, LINE_CAP) / clampu(cl, 1, LOOKS_CAP);
            case ($urandom_range(0, 4))
               0: nc = 0;
               1: nc = 4096;
               2: nc = $urandom_range(1, fit + 2);
               3: nc = 8191;
               default: nc = fit;
            endcase
         end
         md = $urandom_range(0, 3);
         case ($urandom_range(0, 3))
            0: nd = 16'h8000;
            1: nd = 16'h7FFF;
            default: nd = $urandom_range(0, 65535);
         endcase
         write_regs(lw, cl, rl, nc, md, nd);
         frame_len = clampu(lw, 1, LINE_CAP) * clampu(rl, 1, LOOKS_CAP);
         if (frame_len < 200) frame_len *= $urandom_range(1, 3);
         frame_len += $urandom_range(0, clampu(lw, 1, 8));
         // the wide line is only sampled at its start
         if (wide_now) frame_len = WIDE_LEN;
         if (frame_len > ITEM_GOAL - sent_count) frame_len = ITEM_GOAL - sent_count;
         for (int n = 0; n < frame_len; n++) begin
            case ($urandom_range(0, 7))
               0: s = $signed(nd);
               1: s = ($urandom_range(0, 1)) ? 16'sh7FFF : 16'sh8000;
               default: s = $urandom_range(0, 65535);
            endcase
            row = px(s, ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
                     (n == 0) || ($urandom_range(0, 99) == 0));
            send_pixel(row);
         end
      end

      drain();
      if (error_count == 0) begin
         $display("weighted_block_multilook_core test passed");
      end else begin
         $display("weighted_block_multilook_core test failed");
      end
      $finish;
   end

endmodule
